/* hw/rtl/ppu_pkg.sv */
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and helpers of the particle pool update block.
// ----------------------------------------------------------------------------
`default_nettype none
package ppu_pkg;

  localparam int unsigned POOL_SIZE_DEF = 2048;
  localparam logic [16:0] ONE_Q16       = 17'd65536;

  typedef enum logic [1:0] {
    FUNC_SPAWN = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_TK_READ,
    ST_TK_LOAD,
    ST_TK_MATH,
    ST_TK_DIV,
    ST_TK_WRITE,
    ST_CP_READ,
    ST_CP_LOAD,
    ST_CP_CHECK,
    ST_CP_MOVE,
    ST_DONE
  } state_e;

  // Input beat
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] start_pos;
    logic [63:0] start_vel;
    logic [63:0] accel;
    logic [31:0] drag_rate;
    logic [31:0] life_span;
    logic [31:0] fade_begin;
    logic [15:0] sprite_id;
    logic [31:0] camera_mask;
    logic signed [7:0] draw_layer;
    logic [15:0] step_time;
    logic [10:0] entry_index;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic        accepted;
    logic [11:0] live_count;
    logic        entry_valid;
    logic [63:0] prev_position;
    logic [63:0] position;
    logic [16:0] alpha;
    logic [15:0] sprite_out;
    logic [31:0] camera_out;
    logic signed [7:0] layer_out;
  } out_beat_t;

  // One full pool entry as it sits in the memories
  typedef struct packed {
    logic [63:0] pos;
    logic [63:0] prev;
    logic [63:0] vel;
    logic [63:0] acc;
    logic [31:0] drag;
    logic [31:0] life;
    logic [31:0] age;
    logic [31:0] fade;
    logic [16:0] alpha;
    logic [55:0] tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic latch_in;      // capture the input beat
    logic spawn_wr;      // write spawn entry at count
    logic rd_issue;      // read address = entry_index
    logic tk_issue;      // read address = index counter
    logic tk_load;       // capture read data into work register
    logic tk_math;       // run age/velocity stage; position follows
    logic div_start;     // start fade divider
    logic div_step;      // one divider step
    logic tk_write;      // write work register back at index
    logic idx_clr;       // index counter to zero
    logic idx_inc;       // advance index counter
    logic cp_issue_last; // read address = count - 1
    logic cp_move;       // write read data (last entry) at index, count--
    logic cnt_inc;
    logic res_load_rd;   // build result from read data
    logic res_load_st;   // build status-only result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic        full;
    logic        rd_in_range;
    logic        idx_at_end;   // index >= count
    logic        dead;         // work entry age >= life
    logic        need_div;     // fade interpolation needed
    logic        div_done;
    logic [1:0]  func;
  } sts_t;

  // floor(a*b/65536) with a signed 32 and b signed 33, wrapped to 32 bits
  function automatic logic [31:0] mul_floor(input logic signed [31:0] a,
                                            input logic signed [32:0] b);
    logic signed [64:0] p;
    begin
      p = 65'(a) * 65'(b);
      mul_floor = p[47:16];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ppu_stream_if.sv */
// ----------------------------------------------------------------------------
// ppu_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface ppu_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/particle_pool_update.sv */
// ----------------------------------------------------------------------------
// particle_pool_update
// Pool of Q16.16 particles: spawn, Euler tick with fade and compaction, read.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | ppu_pkg::in_beat_t  (func .. entry_index)
//  out     | out | ppu_pkg::out_beat_t (accepted .. layer_out)
//
//  Spawn passes through ST_SPAWN to ST_DONE, read adds ST_RD_WAIT; both then wait
//  for the output handshake. Tick reads, loads, updates and writes back each live
//  entry, running the fade divider for each entry that is fading, then compacts by
//  moving the last entry into each removed one; the single-port entry memory sets the pace.
//  Reset clears the count, index and controller state; entry memory is left as is.
//  A stalled result holds the block; no new beat is taken until it leaves.
`default_nettype none
module particle_pool_update #(
  parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  ppu_stream_if.sink     in_if,
  ppu_stream_if.source   out_if
);
  import ppu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppu_dpath #(.PoolSize(POOL_SIZE)) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_if.data)
  );
endmodule
`default_nettype wire

/* hw/rtl/ppu_ram.sv */
// ----------------------------------------------------------------------------
// ppu_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] addr_i,
  input  wire [Width-1:0]         wdata_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write, and registered read (returns the old data on a write)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/ppu_ctrl.sv */
// ----------------------------------------------------------------------------
// ppu_ctrl
// Sequencer for spawn, read and the two tick passes (update, compaction).
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  input  ppu_pkg::sts_t  sts_i,
  output ppu_pkg::cmd_t  cmd_o
);
  import ppu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_SPAWN;
        end
      end
      ST_SPAWN: begin
        // dispatch on the latched function
        case (func_e'(sts_i.func))
          FUNC_SPAWN: begin
            if (!sts_i.full) begin
              cmd_o.spawn_wr = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
            end
            cmd_o.res_load_st = 1'b1;
            state_d = ST_DONE;
          end
          FUNC_TICK: begin
            cmd_o.idx_clr = 1'b1;
            state_d = ST_TK_READ;
          end
          FUNC_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d = ST_RD_WAIT;
          end
          default: begin
            cmd_o.res_load_st = 1'b1;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RD_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        state_d = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cmd_o.res_load_rd = 1'b1;
        state_d = ST_DONE;
      end
      // update pass
      ST_TK_READ: begin
        if (sts_i.idx_at_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d = ST_CP_READ;
        end else begin
          cmd_o.tk_issue = 1'b1;
          state_d = ST_TK_LOAD;
        end
      end
      ST_TK_LOAD: begin
        cmd_o.tk_load = 1'b1;
        state_d = ST_TK_MATH;
      end
      ST_TK_MATH: begin
        cmd_o.tk_math = 1'b1;
        state_d = ST_TK_DIV;
      end
      ST_TK_DIV: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_TK_WRITE;
        end else begin
          cmd_o.tk_write = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d = ST_TK_READ;
        end
      end
      ST_TK_WRITE: begin
        if (sts_i.div_done) begin
          cmd_o.tk_write = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d = ST_TK_READ;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      // compaction pass
      ST_CP_READ: begin
        if (sts_i.idx_at_end) begin
          cmd_o.res_load_st = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.tk_issue = 1'b1;
          state_d = ST_CP_LOAD;
        end
      end
      ST_CP_LOAD: begin
        cmd_o.tk_load = 1'b1;
        state_d = ST_CP_CHECK;
      end
      ST_CP_CHECK: begin
        if (sts_i.dead) begin
          cmd_o.cp_issue_last = 1'b1;
          state_d = ST_CP_MOVE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_CP_READ;
        end
      end
      ST_CP_MOVE: begin
        cmd_o.tk_load = 1'b1;
        cmd_o.cp_move = 1'b1;
        state_d = ST_CP_READ;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_div_only_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> state_q == ST_TK_WRITE) else $error("stray divider step");
  a_move_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cp_move |-> $past(state_q) == ST_CP_CHECK) else $error("bad move");
endmodule
`default_nettype wire

/* hw/rtl/ppu_dpath.sv */
// ----------------------------------------------------------------------------
// ppu_dpath
// Entry memory, work register, Euler arithmetic, fade divider and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_dpath #(
  parameter int unsigned PoolSize = ppu_pkg::POOL_SIZE_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ppu_pkg::in_beat_t   in_i,
  input  ppu_pkg::cmd_t       cmd_i,
  output ppu_pkg::sts_t       sts_o,
  output ppu_pkg::out_beat_t  out_o
);
  import ppu_pkg::*;

  localparam int unsigned AW = $clog2(PoolSize);
  localparam int unsigned CW = $clog2(PoolSize + 1);

  in_beat_t         in_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    idx_q;
  entry_t           work_q;
  entry_t           rdata;
  entry_t           wdata;
  logic             we;
  logic [AW-1:0]    addr;
  out_beat_t        res_q;
  out_beat_t        res_d;
  logic             spawn_ok;

  // divider: remainder/quotient, 17 quotient bits
  logic [32:0]      rem_q;
  logic [31:0]      den_q;
  logic [48:0]      num_q;
  logic [16:0]      quo_q;
  logic [5:0]       dcnt_q;

  // Euler step terms
  logic [31:0]      dt32;
  logic [47:0]      drag_prod;
  logic [31:0]      dragk;
  logic [31:0]      vx1, vy1, px1, py1;
  logic [63:0]      vel_dk;
  logic [32:0]      age_sum;
  logic [31:0]      age_n;
  logic             math2_q;
  logic [31:0]      kx_q;

  // capture input
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_i;
    end
  end

  // live count and walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.cnt_inc) count_q <= count_q + CW'(1);
      else if (cmd_i.cp_move) count_q <= count_q - CW'(1);
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + CW'(1);
    end
  end

  // memory address and write select
  always_comb begin
    addr = idx_q[AW-1:0];
    if (cmd_i.spawn_wr) addr = count_q[AW-1:0];
    else if (cmd_i.rd_issue) addr = AW'(in_q.entry_index);
    else if (cmd_i.cp_issue_last) addr = AW'(count_q - CW'(1));
    we = cmd_i.spawn_wr || cmd_i.tk_write || cmd_i.cp_move;
    wdata = work_q;
    if (cmd_i.cp_move) wdata = rdata;
    if (cmd_i.spawn_wr) begin
      wdata.pos   = in_q.start_pos;
      wdata.prev  = in_q.start_pos;
      wdata.vel   = in_q.start_vel;
      wdata.acc   = in_q.accel;
      wdata.drag  = in_q.drag_rate;
      wdata.life  = in_q.life_span;
      wdata.fade  = (in_q.fade_begin < in_q.life_span) ? in_q.fade_begin
                                                       : in_q.life_span;
      wdata.age   = '0;
      wdata.alpha = ONE_Q16;
      wdata.tag   = {in_q.sprite_id, in_q.camera_mask, in_q.draw_layer};
    end else if (cmd_i.tk_write) begin
      // write straight after the second step: take its results directly
      if (math2_q) begin
        wdata.pos = {px1, py1};
        wdata.vel = vel_dk;
      end
      if (dcnt_q != 6'd0) begin
        wdata.alpha = ONE_Q16 - quo_q;
      end
    end
  end

  ppu_ram #(.Width(ENTRY_W), .Depth(PoolSize)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign dt32      = {16'd0, in_q.step_time};
  assign drag_prod = work_q.drag * in_q.step_time;
  assign dragk     = 32'(ONE_Q16) - drag_prod[47:16];
  assign age_sum   = {1'b0, work_q.age} + 33'(in_q.step_time);
  assign age_n     = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];

  // first step: velocity from acceleration; second step: position and
  // drag, both from the registered velocity
  always_comb begin
    vx1 = work_q.vel[63:32] + mul_floor(work_q.acc[63:32], 33'(dt32));
    vy1 = work_q.vel[31:0]  + mul_floor(work_q.acc[31:0], 33'(dt32));
    px1 = work_q.pos[63:32] + mul_floor(work_q.vel[63:32], 33'(dt32));
    py1 = work_q.pos[31:0]  + mul_floor(work_q.vel[31:0], 33'(dt32));
    vel_dk = {mul_floor(work_q.vel[63:32], {kx_q[31], kx_q}),
              mul_floor(work_q.vel[31:0],  {kx_q[31], kx_q})};
  end

  // work register and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q  <= '0;
      math2_q <= 1'b0;
    end else begin
      math2_q <= cmd_i.tk_math;
      if (cmd_i.div_start) dcnt_q <= 6'd49;
      else if (cmd_i.div_step && dcnt_q > 6'd1) dcnt_q <= dcnt_q - 6'd1;
      else if (cmd_i.tk_write || cmd_i.tk_load) dcnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tk_load) begin
      work_q <= rdata;
    end else if (cmd_i.tk_math) begin
      work_q.age  <= age_n;
      work_q.prev <= work_q.pos;
      work_q.vel  <= {vx1, vy1};
      kx_q        <= dragk;
      if (age_n >= work_q.life) work_q.alpha <= '0;
      else if (age_n <= work_q.fade) work_q.alpha <= ONE_Q16;
    end else if (math2_q) begin
      work_q.pos <= {px1, py1};
      work_q.vel <= vel_dk;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      num_q <= {work_q.age - work_q.fade, 17'd0};
      den_q <= work_q.life - work_q.fade;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ({rem_q[31:0], num_q[48]} >= {1'b0, den_q})
               ? {rem_q[31:0], num_q[48]} - {1'b0, den_q}
               : {rem_q[31:0], num_q[48]};
      quo_q <= {quo_q[15:0],
                ({rem_q[31:0], num_q[48]} >= {1'b0, den_q})};
      num_q <= {num_q[47:0], 1'b0};
    end
  end

  // status
  always_comb begin
    sts_o.full        = (count_q >= CW'(PoolSize));
    sts_o.rd_in_range = ({21'd0, in_q.entry_index} < 32'(count_q));
    sts_o.idx_at_end  = (idx_q >= count_q);
    sts_o.dead        = (work_q.age >= work_q.life);
    sts_o.need_div    = (work_q.age < work_q.life) && (work_q.age > work_q.fade);
    sts_o.div_done    = (dcnt_q == 6'd1);
    sts_o.func        = in_q.func;
  end

  // build the result beat
  assign spawn_ok = (in_q.func == FUNC_SPAWN) && !sts_o.full;

  always_comb begin
    res_d            = '0;
    res_d.live_count = 12'(count_q);
    if (cmd_i.res_load_st) begin
      res_d.accepted   = spawn_ok;
      res_d.live_count = 12'(count_q + CW'(spawn_ok));
    end
    if (cmd_i.res_load_rd && sts_o.rd_in_range) begin
      res_d.entry_valid   = 1'b1;
      res_d.prev_position = rdata.prev;
      res_d.position      = rdata.pos;
      res_d.alpha         = rdata.alpha;
      res_d.sprite_out    = rdata.tag[55:40];
      res_d.camera_out    = rdata.tag[39:8];
      res_d.layer_out     = rdata.tag[7:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load_st || cmd_i.res_load_rd) begin
      res_q <= res_d;
    end
  end
  assign out_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PoolSize)) else $error("count overflow");
  a_no_inc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !sts_o.full) else $error("spawn into full pool");
  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cp_move |-> count_q != '0) else $error("move from empty pool");
endmodule
`default_nettype wire
